>>> design/bir_pkg.sv
// Shared constants for the bilinear image remap block.
`default_nettype none
package bir_pkg;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = 16;
    localparam int BANK_AW    = ADDR_W - 1;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int COORD_W    = 20;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int DIM_W      = CFG_W;
    localparam int XI_W       = $clog2(MAX_WIDTH);
    localparam int YI_W       = $clog2(MAX_HEIGHT);
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int LERP_W     = CHAN_W + FRAC_BITS;
    localparam int ACC_W      = CHAN_W + 2 * FRAC_BITS;
    localparam int HI_W       = DIM_W + FRAC_BITS;
    localparam int CMP_W      = ((COORD_W > HI_W) ? COORD_W : HI_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_REMAP = 1'b1;
endpackage
`default_nettype wire

>>> design/bir_if.sv
// Channel interfaces: input items, result items, configuration writes.
`default_nettype none
interface bir_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [bir_pkg::ADDR_W-1:0]        pixel_addr;
    logic [bir_pkg::CHAN_W-1:0]        red_in;
    logic [bir_pkg::CHAN_W-1:0]        green_in;
    logic [bir_pkg::CHAN_W-1:0]        blue_in;
    logic signed [bir_pkg::COORD_W-1:0] map_x;
    logic signed [bir_pkg::COORD_W-1:0] map_y;
    modport source (output valid, kind, pixel_addr, red_in, green_in, blue_in, map_x, map_y,
                    input ready);
    modport sink (input valid, kind, pixel_addr, red_in, green_in, blue_in, map_x, map_y,
                  output ready);
endinterface

interface bir_out_if;
    logic                       valid;
    logic                       ready;
    logic [bir_pkg::CHAN_W-1:0] out_red;
    logic [bir_pkg::CHAN_W-1:0] out_green;
    logic [bir_pkg::CHAN_W-1:0] out_blue;
    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface bir_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bir_pkg::CFG_IDX_W-1:0] index;
    logic [bir_pkg::CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/bir_ram.sv
// Source image bank: one write port, two registered read ports.
`default_nettype none
module bir_ram #(
    parameter int AW = 15,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output      logic [DW-1:0] o_rdata0,
    output      logic [DW-1:0] o_rdata1
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

>>> design/bilinear_image_remap.sv
// Bilinear RGB remap over an on-chip source image held in two parity banks.
//
//  channel   | dir | payload                                          | accepted when
//  i_in_ch   | in  | kind pixel_addr red_in green_in blue_in map_x/y  | valid && ready
//  o_out_ch  | out | out_red out_green out_blue                        | valid && ready
//  i_cfg_ch  | in  | index (0 width, 1 height), data                  | valid && ready
//
// One item per cycle while the skid entry is empty; remaps pass clamp, address, bank, lerp and output registers.
// Each row pair of neighbors hits one even and one odd entry, so the two dual-read banks
// serve all four reads in the same cycle. Loads write in the same stage remaps read: no hazard.
// Synchronous reset clears valids and sets width and height to 256; no store clearing.
// A two-entry output buffer lets the pipeline move while one result waits; ready drops
// only when both entries are full.
`default_nettype none
module bilinear_image_remap (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bir_in_if.sink      i_in_ch,
    bir_out_if.source   o_out_ch,
    bir_cfg_if.sink     i_cfg_ch
);
    localparam int FB = bir_pkg::FRAC_BITS;
    localparam int CW = bir_pkg::CHAN_W;

    logic [bir_pkg::DIM_W-1:0] r_w_eff, r_h_eff, n_w_eff, n_h_eff;
    logic en;

    // configuration, stored saturated
    assign i_cfg_ch.ready = 1'b1;
    always_comb begin
        n_w_eff = r_w_eff;
        n_h_eff = r_h_eff;
        if (i_cfg_ch.valid) begin
            if (i_cfg_ch.index == bir_pkg::REG_WIDTH) begin
                if (i_cfg_ch.data < bir_pkg::CFG_W'(2)) n_w_eff = bir_pkg::DIM_W'(2);
                else if (i_cfg_ch.data > bir_pkg::CFG_W'(bir_pkg::MAX_WIDTH))
                    n_w_eff = bir_pkg::DIM_W'(bir_pkg::MAX_WIDTH);
                else n_w_eff = i_cfg_ch.data;
            end else if (i_cfg_ch.index == bir_pkg::REG_HEIGHT) begin
                if (i_cfg_ch.data < bir_pkg::CFG_W'(2)) n_h_eff = bir_pkg::DIM_W'(2);
                else if (i_cfg_ch.data > bir_pkg::CFG_W'(bir_pkg::MAX_HEIGHT))
                    n_h_eff = bir_pkg::DIM_W'(bir_pkg::MAX_HEIGHT);
                else n_h_eff = i_cfg_ch.data;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= bir_pkg::DIM_W'(bir_pkg::MAX_WIDTH);
            r_h_eff <= bir_pkg::DIM_W'(bir_pkg::MAX_HEIGHT);
        end else begin
            r_w_eff <= n_w_eff;
            r_h_eff <= n_h_eff;
        end
    end

    // stage 1: clamp and split coordinates
    logic signed [bir_pkg::CMP_W-1:0] vx, vy, hx, hy, cx, cy;
    always_comb begin
        vx = {{(bir_pkg::CMP_W-bir_pkg::COORD_W){i_in_ch.map_x[bir_pkg::COORD_W-1]}},
              i_in_ch.map_x};
        vy = {{(bir_pkg::CMP_W-bir_pkg::COORD_W){i_in_ch.map_y[bir_pkg::COORD_W-1]}},
              i_in_ch.map_y};
        hx = {{(bir_pkg::CMP_W-bir_pkg::HI_W){1'b0}}, r_w_eff - bir_pkg::DIM_W'(2),
              {FB{1'b0}}};
        hy = {{(bir_pkg::CMP_W-bir_pkg::HI_W){1'b0}}, r_h_eff - bir_pkg::DIM_W'(2),
              {FB{1'b0}}};
        cx = vx;
        if (vx < 0) cx = '0;
        else if (vx > hx) cx = hx;
        cy = vy;
        if (vy < 0) cy = '0;
        else if (vy > hy) cy = hy;
    end

    logic                         r1_valid, r1_kind;
    logic [bir_pkg::ADDR_W-1:0]   r1_addr;
    logic [bir_pkg::PIX_W-1:0]    r1_pix;
    logic [bir_pkg::XI_W-1:0]     r1_x1;
    logic [bir_pkg::YI_W-1:0]     r1_y1;
    logic [FB-1:0]                r1_fx, r1_fy;

    assign i_in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in_ch.valid;
        end
        if (en) begin
            r1_kind <= i_in_ch.kind;
            r1_addr <= i_in_ch.pixel_addr;
            r1_pix  <= {i_in_ch.red_in, i_in_ch.green_in, i_in_ch.blue_in};
            r1_x1   <= cx[FB +: bir_pkg::XI_W];
            r1_fx   <= cx[FB-1:0];
            r1_y1   <= cy[FB +: bir_pkg::YI_W];
            r1_fy   <= cy[FB-1:0];
        end
    end

    // stage 2: base address y1*w + x1
    logic                       r2_valid, r2_kind;
    logic [bir_pkg::ADDR_W-1:0] r2_addr, r2_base;
    logic [bir_pkg::PIX_W-1:0]  r2_pix;
    logic [FB-1:0]              r2_fx, r2_fy;
    logic [bir_pkg::YI_W+bir_pkg::DIM_W-1:0] row_off;

    assign row_off = (bir_pkg::YI_W+bir_pkg::DIM_W)'(r1_y1) *
                     (bir_pkg::YI_W+bir_pkg::DIM_W)'(r_w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            r2_kind <= r1_kind;
            r2_addr <= r1_addr;
            r2_pix  <= r1_pix;
            r2_base <= bir_pkg::ADDR_W'(row_off) + bir_pkg::ADDR_W'(r1_x1);
            r2_fx   <= r1_fx;
            r2_fy   <= r1_fy;
        end
    end

    // stage 3: bank access; each row pair has one even and one odd entry
    logic [bir_pkg::ADDR_W-1:0]  top0, top1, bot0, bot1, top_ev, top_od, bot_ev, bot_od;
    logic [bir_pkg::PIX_W-1:0]   ev_rd0, ev_rd1, od_rd0, od_rd1;
    logic                        we_ev, we_od, re;

    always_comb begin
        top0   = r2_base;
        top1   = r2_base + bir_pkg::ADDR_W'(1);
        bot0   = r2_base + bir_pkg::ADDR_W'(r_w_eff);
        bot1   = bot0 + bir_pkg::ADDR_W'(1);
        top_ev = top0[0] ? top1 : top0;
        top_od = top0[0] ? top0 : top1;
        bot_ev = bot0[0] ? bot1 : bot0;
        bot_od = bot0[0] ? bot0 : bot1;
        re     = en && r2_valid && (r2_kind == bir_pkg::KIND_REMAP);
        we_ev  = en && r2_valid && (r2_kind == bir_pkg::KIND_LOAD) && !r2_addr[0];
        we_od  = en && r2_valid && (r2_kind == bir_pkg::KIND_LOAD) && r2_addr[0];
    end

    bir_ram #(.AW(bir_pkg::BANK_AW), .DW(bir_pkg::PIX_W)) u_bank_even (
        .i_clk    (i_clk),
        .i_we     (we_ev),
        .i_waddr  (r2_addr[bir_pkg::ADDR_W-1:1]),
        .i_wdata  (r2_pix),
        .i_re     (re),
        .i_raddr0 (top_ev[bir_pkg::ADDR_W-1:1]),
        .i_raddr1 (bot_ev[bir_pkg::ADDR_W-1:1]),
        .o_rdata0 (ev_rd0),
        .o_rdata1 (ev_rd1)
    );

    bir_ram #(.AW(bir_pkg::BANK_AW), .DW(bir_pkg::PIX_W)) u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (we_od),
        .i_waddr  (r2_addr[bir_pkg::ADDR_W-1:1]),
        .i_wdata  (r2_pix),
        .i_re     (re),
        .i_raddr0 (top_od[bir_pkg::ADDR_W-1:1]),
        .i_raddr1 (bot_od[bir_pkg::ADDR_W-1:1]),
        .o_rdata0 (od_rd0),
        .o_rdata1 (od_rd1)
    );

    logic          r3_valid, r3_top_odd, r3_bot_odd;
    logic [FB-1:0] r3_fx, r3_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= re;
        end
        if (en) begin
            r3_top_odd <= top0[0];
            r3_bot_odd <= bot0[0];
            r3_fx      <= r2_fx;
            r3_fy      <= r2_fy;
        end
    end

    // stage 4: horizontal lerp per channel
    logic [bir_pkg::PIX_W-1:0]  q11, q12, q21, q22;
    logic [bir_pkg::WT_W-1:0]   wx0, wx1, wy0, wy1;
    logic [bir_pkg::LERP_W-1:0] h_top [3];
    logic [bir_pkg::LERP_W-1:0] h_bot [3];
    logic [CW-1:0]              res [3];

    always_comb begin
        q11 = r3_top_odd ? od_rd0 : ev_rd0;
        q12 = r3_top_odd ? ev_rd0 : od_rd0;
        q21 = r3_bot_odd ? od_rd1 : ev_rd1;
        q22 = r3_bot_odd ? ev_rd1 : od_rd1;
        wx1 = {1'b0, r3_fx};
        wx0 = (bir_pkg::WT_W'(1) << FB) - wx1;
        for (int c = 0; c < 3; c++) begin
            h_top[c] = bir_pkg::LERP_W'(q11[(2-c)*CW +: CW]) * bir_pkg::LERP_W'(wx0) +
                       bir_pkg::LERP_W'(q12[(2-c)*CW +: CW]) * bir_pkg::LERP_W'(wx1);
            h_bot[c] = bir_pkg::LERP_W'(q21[(2-c)*CW +: CW]) * bir_pkg::LERP_W'(wx0) +
                       bir_pkg::LERP_W'(q22[(2-c)*CW +: CW]) * bir_pkg::LERP_W'(wx1);
        end
    end

    logic                       r4_valid;
    logic [bir_pkg::LERP_W-1:0] r4_top [3];
    logic [bir_pkg::LERP_W-1:0] r4_bot [3];
    logic [FB-1:0]              r4_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
        if (en) begin
            r4_top <= h_top;
            r4_bot <= h_bot;
            r4_fy  <= r3_fy;
        end
    end

    // vertical lerp; the sum never exceeds 255 << 2*FRAC_BITS
    logic [bir_pkg::ACC_W-1:0] acc [3];
    always_comb begin
        wy1 = {1'b0, r4_fy};
        wy0 = (bir_pkg::WT_W'(1) << FB) - wy1;
        for (int c = 0; c < 3; c++) begin
            acc[c] = bir_pkg::ACC_W'(r4_top[c]) * bir_pkg::ACC_W'(wy0) +
                     bir_pkg::ACC_W'(r4_bot[c]) * bir_pkg::ACC_W'(wy1);
            res[c] = acc[c][2*FB +: CW];
        end
    end

    // output register plus skid entry
    logic                      r_ov, r_sv, push, pop;
    logic [bir_pkg::PIX_W-1:0] r_out, r_skid, new_pix;

    assign en      = !r_sv;
    assign push    = en && r4_valid;
    assign pop     = r_ov && o_out_ch.ready;
    assign new_pix = {res[0], res[1], res[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= push;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_sv <= 1'b1;
        end
        if (!r_ov || pop) begin
            r_out <= r_sv ? r_skid : new_pix;
            if (push) r_skid <= new_pix;
        end else if (push) begin
            r_skid <= new_pix;
        end
    end

    assign o_out_ch.valid     = r_ov;
    assign o_out_ch.out_red   = r_out[2*CW +: CW];
    assign o_out_ch.out_green = r_out[CW +: CW];
    assign o_out_ch.out_blue  = r_out[0 +: CW];
endmodule
`default_nettype wire

>>> design/bir_checker.sv
// Port-level checks for the remap block, bound to the top level.
`default_nettype none
module bir_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_cfg_ready
);
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("cfg ready low");

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready fell without an output stall");
endmodule

bind bilinear_image_remap bir_checker u_bir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_cfg_ready (i_cfg_ch.ready)
);
`default_nettype wire
